@@ rtl/perceptron_tournament_branch_predictor_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PERCEPTRON_TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define PERCEPTRON_TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PTBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PTBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ptbp_pkg.sv @@
`timescale 1ns / 1ps

package ptbp_pkg;

  localparam int GHIST_BITS_DEF    = 12;
  localparam int LHIST_BITS_DEF    = 10;
  localparam int PC_INDEX_BITS_DEF = 9;
  localparam int WEIGHT_BITS_DEF   = 8;

  localparam int PC_W      = 32;
  localparam int SUM_OUT_W = 12;

  // request kinds
  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_TRAIN   = 1'b1;

  // 2-bit saturating counters
  localparam logic [1:0] CTR_MIN      = 2'd0;
  localparam logic [1:0] CTR_MAX      = 2'd3;
  localparam logic [1:0] CTR_WEAK_NT  = 2'd1;
  localparam logic [1:0] CHOOSE_WEAK_P = 2'd2;

  function automatic logic [1:0] ctr_inc(input logic [1:0] c);
    logic [1:0] r;
    r = (c == CTR_MAX) ? c : c + 2'd1;
    return r;
  endfunction

  function automatic logic [1:0] ctr_dec(input logic [1:0] c);
    logic [1:0] r;
    r = (c == CTR_MIN) ? c : c - 2'd1;
    return r;
  endfunction

  // Width that holds bias plus lhist signed weight terms without overflow.
  function automatic int sum_width(input int wbits, input int lbits);
    int r;
    r = wbits + $clog2(lbits + 1);
    return r;
  endfunction

endpackage

@@ rtl/ptbp_gtable.sv @@
`timescale 1ns / 1ps

// Global table: {chooser, pattern counter} per global history value.
module ptbp_gtable #(
  parameter int GHIST_BITS = ptbp_pkg::GHIST_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [GHIST_BITS-1:0] waddr_i,
  input  logic [3:0]            wdata_i,
  input  logic                  re_i,
  input  logic [GHIST_BITS-1:0] raddr_i,
  output logic [3:0]            rdata_o
);

  localparam int DEPTH = 1 << GHIST_BITS;

  logic [3:0] mem [DEPTH];
  logic [3:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptbp_ltable.sv @@
`timescale 1ns / 1ps

// Local table: one row per pc index with {weights, bias, local history}.
module ptbp_ltable #(
  parameter int PC_INDEX_BITS = ptbp_pkg::PC_INDEX_BITS_DEF,
  parameter int ROW_W         = 98
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [PC_INDEX_BITS-1:0] waddr_i,
  input  logic [ROW_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [PC_INDEX_BITS-1:0] raddr_i,
  output logic [ROW_W-1:0]         rdata_o
);

  localparam int DEPTH = 1 << PC_INDEX_BITS;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ptbp_percep.sv @@
`timescale 1ns / 1ps

// Perceptron dot product, one weight term per cycle.
module ptbp_percep #(
  parameter int LHIST_BITS  = ptbp_pkg::LHIST_BITS_DEF,
  parameter int WEIGHT_BITS = ptbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [WEIGHT_BITS-1:0]       bias_i,
  input  logic [LHIST_BITS*WEIGHT_BITS-1:0]   weights_i,
  input  logic [LHIST_BITS-1:0]               hist_i,
  output logic signed [ptbp_pkg::sum_width(WEIGHT_BITS, LHIST_BITS)-1:0] sum_o,
  output logic                                done_o
);

  localparam int SUM_W = ptbp_pkg::sum_width(WEIGHT_BITS, LHIST_BITS);
  localparam int IDX_W = (LHIST_BITS > 1) ? $clog2(LHIST_BITS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LHIST_BITS - 1);

  logic                          busy_q, busy_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic signed [SUM_W-1:0]       acc_q, acc_d;
  logic signed [WEIGHT_BITS-1:0] w_cur;
  logic signed [SUM_W-1:0]       w_ext;
  logic                          last;

  assign w_cur = weights_i[idx_q*WEIGHT_BITS +: WEIGHT_BITS];
  assign w_ext = SUM_W'(w_cur);
  assign last  = (idx_q == IDX_LAST);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      acc_d  = SUM_W'(bias_i);
    end else if (busy_q) begin
      acc_d = hist_i[idx_q] ? acc_q + w_ext : acc_q - w_ext;
      idx_d = idx_q + IDX_W'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // final term lands at this edge
  assign done_o = busy_q && last;
  assign sum_o  = acc_q;

endmodule

@@ rtl/perceptron_tournament_branch_predictor.sv @@
`timescale 1ns / 1ps

// Tournament perceptron branch predictor.
// Input channel (in_valid_i / in_stall_o) carries one request beat: req_type_i
// selects predict or train, pc_i gives the branch address, outcome_i the
// resolved direction for train beats. Every request yields exactly one result
// beat on the output channel (out_valid_o / out_stall_i): the combined
// prediction, whether the chooser picked the perceptron, and the perceptron
// sum, all taken from the state as it was before the request.
// Timing: one request in flight. From accept to result valid a beat passes
// through the table read, the perceptron accumulator (one term per local
// history bit) and the write-back step. The next request is accepted the
// cycle after the result loads, so requests never overlap and the
// accumulator loop sets the request rate.
// Reset: after rst_ni releases, a clearing pass writes every table row;
// in_stall_o stays high until it ends.
// Output stall: a finished result sits in the output register and a new
// request is still accepted; the write-back of that next request holds,
// with no table update, until the output register frees up.
module perceptron_tournament_branch_predictor #(
  parameter int GHIST_BITS    = ptbp_pkg::GHIST_BITS_DEF,
  parameter int LHIST_BITS    = ptbp_pkg::LHIST_BITS_DEF,
  parameter int PC_INDEX_BITS = ptbp_pkg::PC_INDEX_BITS_DEF,
  parameter int WEIGHT_BITS   = ptbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [ptbp_pkg::PC_W-1:0]             pc_i,
  input  logic                                  outcome_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  prediction_o,
  output logic                                  chose_perceptron_o,
  output logic signed [ptbp_pkg::SUM_OUT_W-1:0] perceptron_sum_o
);

  localparam int SUM_W  = ptbp_pkg::sum_width(WEIGHT_BITS, LHIST_BITS);
  localparam int EXT_W  = (SUM_W > ptbp_pkg::SUM_OUT_W) ? SUM_W : ptbp_pkg::SUM_OUT_W;
  localparam int ROW_W  = LHIST_BITS + WEIGHT_BITS + LHIST_BITS * WEIGHT_BITS;
  localparam int BIAS_LO = LHIST_BITS;
  localparam int WTS_LO  = LHIST_BITS + WEIGHT_BITS;
  localparam int CLR_W  = (GHIST_BITS > PC_INDEX_BITS) ? GHIST_BITS : PC_INDEX_BITS;
  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_WRITE
  } state_e;

  state_e                      state_q;
  logic [CLR_W-1:0]            clr_q;
  logic [GHIST_BITS-1:0]       ghist_q;
  logic                        req_q;
  logic                        outcome_q;
  logic [PC_INDEX_BITS-1:0]    lidx_q;
  logic                        out_valid_q;
  logic                        pred_q;
  logic                        usep_q;
  logic signed [ptbp_pkg::SUM_OUT_W-1:0] sum_q;

  // table ports
  logic                        g_we, g_re;
  logic [GHIST_BITS-1:0]       g_waddr;
  logic [3:0]                  g_wdata, g_rdata;
  logic                        l_we, l_re;
  logic [PC_INDEX_BITS-1:0]    l_waddr;
  logic [ROW_W-1:0]            l_wdata, l_rdata;

  // perceptron unit
  logic                        p_start, p_done;
  logic signed [SUM_W-1:0]     p_sum;

  // write-back
  logic                        in_fire, wb_fire, is_train;
  logic [1:0]                  pat, chs, pat_new, chs_new;
  logic                        pres, gres, usep, miss;
  logic [LHIST_BITS-1:0]       lhist, lhist_new;
  logic signed [WEIGHT_BITS-1:0] bias_new;
  logic [LHIST_BITS*WEIGHT_BITS-1:0] wts_new;
  logic signed [EXT_W-1:0]     sum_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign wb_fire    = (state_q == ST_WRITE) && (!out_valid_q || !out_stall_i);
  assign is_train   = (req_q == ptbp_pkg::REQ_TRAIN);

  assign pat   = g_rdata[1:0];
  assign chs   = g_rdata[3:2];
  assign lhist = l_rdata[LHIST_BITS-1:0];
  assign pres  = (p_sum > 0);
  assign gres  = pat[1];
  assign usep  = chs[1];
  assign miss  = (pres != outcome_q);

  assign sum_ext = EXT_W'(p_sum);

  always_comb begin
    chs_new = chs;
    if (miss && (gres == outcome_q)) begin
      chs_new = ptbp_pkg::ctr_dec(chs);
    end else if (!miss && (gres != outcome_q)) begin
      chs_new = ptbp_pkg::ctr_inc(chs);
    end
    pat_new = outcome_q ? ptbp_pkg::ctr_inc(pat) : ptbp_pkg::ctr_dec(pat);
  end

  // Move every weight one step toward the outcome on a perceptron miss.
  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    logic                          up;
    bias_new = $signed(l_rdata[BIAS_LO +: WEIGHT_BITS]);
    if (miss) begin
      if (outcome_q) begin
        bias_new = (bias_new == W_MAX) ? bias_new : bias_new + WEIGHT_BITS'(1);
      end else begin
        bias_new = (bias_new == W_MIN) ? bias_new : bias_new - WEIGHT_BITS'(1);
      end
    end
    for (int i = 0; i < LHIST_BITS; i++) begin
      w  = $signed(l_rdata[WTS_LO + i*WEIGHT_BITS +: WEIGHT_BITS]);
      up = (lhist[i] == outcome_q);
      if (miss) begin
        if (up) begin
          w = (w == W_MAX) ? w : w + WEIGHT_BITS'(1);
        end else begin
          w = (w == W_MIN) ? w : w - WEIGHT_BITS'(1);
        end
      end
      wts_new[i*WEIGHT_BITS +: WEIGHT_BITS] = w;
    end
  end

  assign lhist_new = LHIST_BITS'({lhist, outcome_q});

  // Table port steering: clearing pass, read on accept, write-back on train.
  always_comb begin
    g_re    = in_fire;
    l_re    = in_fire;
    g_we    = 1'b0;
    l_we    = 1'b0;
    g_waddr = ghist_q;
    l_waddr = lidx_q;
    g_wdata = {chs_new, pat_new};
    l_wdata = {wts_new, bias_new, lhist_new};
    if (state_q == ST_CLEAR) begin
      g_we    = 1'b1;
      l_we    = 1'b1;
      g_waddr = clr_q[GHIST_BITS-1:0];
      l_waddr = clr_q[PC_INDEX_BITS-1:0];
      g_wdata = {ptbp_pkg::CHOOSE_WEAK_P, ptbp_pkg::CTR_WEAK_NT};
      l_wdata = '0;
    end else if (wb_fire && is_train) begin
      g_we = 1'b1;
      l_we = 1'b1;
    end
  end

  assign p_start = (state_q == ST_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ghist_q     <= '0;
      req_q       <= ptbp_pkg::REQ_PREDICT;
      outcome_q   <= 1'b0;
      lidx_q      <= '0;
      out_valid_q <= 1'b0;
      pred_q      <= 1'b0;
      usep_q      <= 1'b0;
      sum_q       <= '0;
    end else begin
      // load a new result, or drop the one the receiver just took
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == {CLR_W{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            req_q     <= req_type_i;
            outcome_q <= outcome_i;
            lidx_q    <= pc_i[PC_INDEX_BITS-1:0];
            state_q   <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (p_done) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          // hold until the output register is free, then update once
          if (wb_fire) begin
            pred_q      <= usep ? pres : gres;
            usep_q      <= usep;
            sum_q       <= sum_ext[ptbp_pkg::SUM_OUT_W-1:0];
            if (is_train) begin
              ghist_q <= GHIST_BITS'({ghist_q, outcome_q});
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  ptbp_gtable #(
    .GHIST_BITS (GHIST_BITS)
  ) u_gtable (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (ghist_q),
    .rdata_o (g_rdata)
  );

  ptbp_ltable #(
    .PC_INDEX_BITS (PC_INDEX_BITS),
    .ROW_W         (ROW_W)
  ) u_ltable (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (pc_i[PC_INDEX_BITS-1:0]),
    .rdata_o (l_rdata)
  );

  ptbp_percep #(
    .LHIST_BITS  (LHIST_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_percep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (p_start),
    .bias_i    ($signed(l_rdata[BIAS_LO +: WEIGHT_BITS])),
    .weights_i (l_rdata[ROW_W-1:WTS_LO]),
    .hist_i    (lhist),
    .sum_o     (p_sum),
    .done_o    (p_done)
  );

  assign out_valid_o        = out_valid_q;
  assign prediction_o       = pred_q;
  assign chose_perceptron_o = usep_q;
  assign perceptron_sum_o   = sum_q;

endmodule

@@ rtl/ptbp_checker.sv @@
`timescale 1ns / 1ps
`include "perceptron_tournament_branch_predictor_assert.svh"

module ptbp_checker #(
  parameter int LHIST_BITS  = ptbp_pkg::LHIST_BITS_DEF,
  parameter int WEIGHT_BITS = ptbp_pkg::WEIGHT_BITS_DEF
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic                                  prediction_o,
  input logic                                  chose_perceptron_o,
  input logic signed [ptbp_pkg::SUM_OUT_W-1:0] perceptron_sum_o
);

  // the reported sum is exact when the full sum fits the field
  localparam logic SUM_EXACT =
    (ptbp_pkg::sum_width(WEIGHT_BITS, LHIST_BITS) <= ptbp_pkg::SUM_OUT_W);

  `PTBP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o,
    "result beat dropped while stalled")

  `PTBP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(prediction_o) && $stable(chose_perceptron_o) && $stable(perceptron_sum_o),
    "result payload changed while stalled")

  `PTBP_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o,
    "second request accepted back to back")

  `PTBP_ASSERT_NOW(a_percep_pick, clk_i, rst_ni,
    out_valid_o && chose_perceptron_o && SUM_EXACT,
    prediction_o == (perceptron_sum_o > 0),
    "perceptron pick disagrees with sum sign")

endmodule

bind perceptron_tournament_branch_predictor ptbp_checker #(
  .LHIST_BITS  (LHIST_BITS),
  .WEIGHT_BITS (WEIGHT_BITS)
) u_ptbp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .prediction_o       (prediction_o),
  .chose_perceptron_o (chose_perceptron_o),
  .perceptron_sum_o   (perceptron_sum_o)
);

@@ tb/perceptron_tournament_branch_predictor_tb.sv @@
`timescale 1ns / 1ps

module perceptron_tournament_branch_predictor_tb;

  // Widths of the default build; the mirror below runs at these sizes.
  localparam int GH_W  = ptbp_pkg::GHIST_BITS_DEF;
  localparam int LH_W  = ptbp_pkg::LHIST_BITS_DEF;
  localparam int PCI_W = ptbp_pkg::PC_INDEX_BITS_DEF;
  localparam int W_W   = ptbp_pkg::WEIGHT_BITS_DEF;
  localparam int PC_W  = ptbp_pkg::PC_W;
  localparam int SUM_OUT_W = ptbp_pkg::SUM_OUT_W;

  localparam int GH_ROWS = 1 << GH_W;
  localparam int LT_ROWS = 1 << PCI_W;
  localparam int W_MAX   = (1 << (W_W - 1)) - 1;
  localparam int W_MIN   = -(1 << (W_W - 1));

  // A 2-bit counter at or above this value votes taken (or perceptron).
  localparam logic [1:0] CTR_UPPER = 2'd2;

  localparam int RANDOM_BEATS = 1750;

  typedef struct packed {
    logic                        prediction;
    logic                        chose_perceptron;
    logic signed [SUM_OUT_W-1:0] perceptron_sum;
  } verdict_t;

  // Mirror of the predictor tables. Each accepted request beat is replayed
  // here in order; the verdict it owes is queued until the result beat shows.
  class branch_mirror;
    logic [GH_W-1:0]       ghist;
    logic [1:0]            pattern_ctr [GH_ROWS];
    logic [1:0]            chooser_ctr [GH_ROWS];
    logic [LH_W-1:0]       local_hist  [LT_ROWS];
    logic signed [W_W-1:0] bias_w      [LT_ROWS];
    logic signed [W_W-1:0] hist_w      [LT_ROWS][LH_W];
    verdict_t              owed_verdicts[$];
    int                    faults;

    function new();
      ghist  = '0;
      faults = 0;
      foreach (pattern_ctr[g]) begin
        pattern_ctr[g] = ptbp_pkg::CTR_WEAK_NT;
        chooser_ctr[g] = ptbp_pkg::CHOOSE_WEAK_P;
      end
      foreach (local_hist[r]) begin
        local_hist[r] = '0;
        bias_w[r]     = '0;
        for (int i = 0; i < LH_W; i++) hist_w[r][i] = '0;
      end
    endfunction

    function automatic logic signed [W_W-1:0] nudge(logic signed [W_W-1:0] w, int step);
      int v;
      v = int'(w) + step;
      if (v > W_MAX) v = W_MAX;
      if (v < W_MIN) v = W_MIN;
      return v[W_W-1:0];
    endfunction

    function int owed();
      return owed_verdicts.size();
    endfunction

    function void note_request(logic kind, logic [PC_W-1:0] pc, logic taken);
      int              gi;
      int              li;
      int              acc;
      int              t;
      logic [LH_W-1:0] hist;
      logic            p_dir;
      logic            c_dir;
      logic            use_p;
      verdict_t        v;
      gi   = int'(ghist);
      li   = int'(pc[PCI_W-1:0]);
      hist = local_hist[li];
      acc  = int'(bias_w[li]);
      for (int i = 0; i < LH_W; i++)
        acc = hist[i] ? acc + int'(hist_w[li][i]) : acc - int'(hist_w[li][i]);
      p_dir = (acc > 0);
      c_dir = (pattern_ctr[gi] >= CTR_UPPER);
      use_p = (chooser_ctr[gi] >= CTR_UPPER);
      v.prediction       = use_p ? p_dir : c_dir;
      v.chose_perceptron = use_p;
      v.perceptron_sum   = acc[SUM_OUT_W-1:0];
      owed_verdicts.push_back(v);
      if (kind == ptbp_pkg::REQ_TRAIN) begin
        if (p_dir != taken) begin
          t = taken ? 1 : -1;
          bias_w[li] = nudge(bias_w[li], t);
          for (int i = 0; i < LH_W; i++)
            hist_w[li][i] = nudge(hist_w[li][i], hist[i] ? t : -t);
        end
        if (p_dir != taken && c_dir == taken) begin
          if (chooser_ctr[gi] != ptbp_pkg::CTR_MIN) chooser_ctr[gi] = chooser_ctr[gi] - 2'd1;
        end else if (p_dir == taken && c_dir != taken) begin
          if (chooser_ctr[gi] != ptbp_pkg::CTR_MAX) chooser_ctr[gi] = chooser_ctr[gi] + 2'd1;
        end
        if (taken) begin
          if (pattern_ctr[gi] != ptbp_pkg::CTR_MAX) pattern_ctr[gi] = pattern_ctr[gi] + 2'd1;
        end else begin
          if (pattern_ctr[gi] != ptbp_pkg::CTR_MIN) pattern_ctr[gi] = pattern_ctr[gi] - 2'd1;
        end
        local_hist[li] = {hist[LH_W-2:0], taken};
        ghist          = {ghist[GH_W-2:0], taken};
      end
    endfunction

    function void check_result(logic pred, logic chose, logic signed [SUM_OUT_W-1:0] sum);
      verdict_t v;
      if (owed_verdicts.size() == 0) begin
        $display("%0t: result beat with no request pending (prediction %0d, chose %0d, sum %0d)",
                 $time, pred, chose, sum);
        faults++;
        return;
      end
      v = owed_verdicts.pop_front();
      if (pred !== v.prediction) begin
        $display("%0t: prediction mismatch: expected %0d, actual %0d",
                 $time, v.prediction, pred);
        faults++;
      end
      if (chose !== v.chose_perceptron) begin
        $display("%0t: chose_perceptron mismatch: expected %0d, actual %0d",
                 $time, v.chose_perceptron, chose);
        faults++;
      end
      if (sum !== v.perceptron_sum) begin
        $display("%0t: perceptron_sum mismatch: expected %0d, actual %0d",
                 $time, v.perceptron_sum, sum);
        faults++;
      end
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i  = ptbp_pkg::REQ_PREDICT;
  logic [PC_W-1:0]      pc_i        = '0;
  logic                 outcome_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 prediction_o;
  logic                 chose_perceptron_o;
  logic signed [SUM_OUT_W-1:0] perceptron_sum_o;

  branch_mirror book;
  int           beats_sent = 0;
  int           burst_left = 0;

  // Receiver stall pattern: a period and a duty that are redrawn whenever
  // stall_hold runs out; a zero duty gives a stretch with no stall at all.
  int stall_period = 1;
  int stall_duty   = 0;
  int stall_phase  = 0;
  int stall_hold   = 0;

  perceptron_tournament_branch_predictor u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .pc_i               (pc_i),
    .outcome_i          (outcome_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .prediction_o       (prediction_o),
    .chose_perceptron_o (chose_perceptron_o),
    .perceptron_sum_o   (perceptron_sum_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every result beat at the edge that takes it, then advance the
  // stall pattern for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      book.check_result(prediction_o, chose_perceptron_o, perceptron_sum_o);
    if (stall_hold == 0) begin
      stall_hold   = $urandom_range(64, 512);
      stall_period = $urandom_range(1, 16);
      stall_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
    end
    stall_hold  = stall_hold - 1;
    stall_phase = (stall_phase + 1) % stall_period;
    out_stall_i <= (stall_phase < stall_duty);
  end

  // Send one request beat. Called at a rising edge; returns at the edge that
  // accepts the beat. Bursts of random length are split by random gaps, and
  // the fields carry junk while valid is low.
  task automatic send_beat(input logic kind, input logic [PC_W-1:0] pc, input logic taken);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        req_type_i <= 1'($urandom_range(0, 1));
        pc_i       <= $urandom();
        outcome_i  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    pc_i       <= pc;
    outcome_i  <= taken;
    do @(posedge clk_i); while (in_stall_o);
    book.note_request(kind, pc, taken);
    beats_sent++;
  endtask

  initial begin
    logic [PCI_W-1:0] hot_rows [8];
    logic [PC_W-1:0]  pc;
    logic [7:0]       pat;
    int               trips;
    int               per;
    int               len;
    int               stop_at;
    book = new();
    foreach (hot_rows[h]) hot_rows[h] = PCI_W'($urandom());
    hot_rows[0] = '0;
    hot_rows[7] = '1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fresh tables, field extremes, outcome ignored on predict,
    // upper pc bits ignored, then a run of trains that moves the weights.
    send_beat(ptbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b1);
    send_beat(ptbp_pkg::REQ_TRAIN,   32'h0000_0000, 1'b1);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'h0000_0200, 1'b0);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'hFFFF_FE00, 1'b1);
    send_beat(ptbp_pkg::REQ_TRAIN,   32'hFFFF_FE00, 1'b0);
    send_beat(ptbp_pkg::REQ_TRAIN,   32'h0000_01FF, 1'b1);
    send_beat(ptbp_pkg::REQ_TRAIN,   32'hFFFF_FFFF, 1'b1);
    send_beat(ptbp_pkg::REQ_TRAIN,   32'h8000_01FF, 1'b0);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'h7FFF_FFFF, 1'b1);
    for (int k = 0; k < 6; k++) send_beat(ptbp_pkg::REQ_TRAIN, 32'hA5A5_A055, 1'b1);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'h5A5A_5E55, 1'b0);
    for (int k = 0; k < 4; k++) send_beat(ptbp_pkg::REQ_TRAIN, 32'h0000_0055, 1'b0);
    send_beat(ptbp_pkg::REQ_PREDICT, 32'h0000_0055, 1'b1);

    // Random: mostly well-formed branch streams on a few hot rows (loops
    // that exit once, periodic patterns), with fully random noise mixed in.
    // Upper pc bits are fresh on every beat.
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          trips = $urandom_range(1, 12);
          for (int k = 0; k < trips; k++) begin
            pc = $urandom();
            pc[PCI_W-1:0] = hot_rows[$urandom_range(0, 3)];
            if ($urandom_range(0, 3) != 0)
              send_beat(ptbp_pkg::REQ_PREDICT, pc, 1'($urandom_range(0, 1)));
            send_beat(ptbp_pkg::REQ_TRAIN, pc, k != trips - 1);
          end
        end
        5, 6, 7: begin
          per = $urandom_range(2, 8);
          pat = 8'($urandom());
          len = $urandom_range(8, 30);
          for (int k = 0; k < len; k++) begin
            pc = $urandom();
            pc[PCI_W-1:0] = hot_rows[$urandom_range(4, 7)];
            if ($urandom_range(0, 4) == 0)
              send_beat(ptbp_pkg::REQ_PREDICT, pc, 1'($urandom_range(0, 1)));
            send_beat(ptbp_pkg::REQ_TRAIN, pc, pat[k % per]);
          end
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int k = 0; k < len; k++)
            send_beat(1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain: hold until every owed verdict has arrived, then keep idling so
    // that a stray extra result beat gets caught.
    while (book.owed() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (book.faults == 0 && book.owed() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: the clearing pass plus every beat at its slowest fits well
  // inside this bound.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
